// ===== hw/rtl/bkf_pkg.sv =====
package bkf_pkg;

  typedef logic [7:0] byte_t;
  typedef byte_t [15:0] block_t;

  localparam logic [1:0] ACT_E1  = 2'd0;
  localparam logic [1:0] ACT_E3  = 2'd1;
  localparam logic [1:0] ACT_E21 = 2'd2;
  localparam logic [1:0] ACT_E22 = 2'd3;

  typedef struct packed {
    logic [1:0]  action;
    logic [63:0] key_high;
    logic [63:0] key_low;
    logic [63:0] rand_high;
    logic [63:0] rand_low;
    logic [47:0] device_address;
    logic [31:0] aco_high;
    logic [63:0] aco_low;
    logic [4:0]  pin_length;
  } bkf_in_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } bkf_out_t;

  // Control from the sequencer to the round datapath
  typedef struct packed {
    logic       load;      // load block and key
    logic       round;     // run one half-round
    logic       fold;      // add back the round-one input before this round
    logic       finish;    // add last subkey
    logic [2:0] rnd;       // round number 0..7
  } bkf_ctl_t;

  // 45^i mod 257, truncated to a byte
  function automatic byte_t exp45(input byte_t a);
    logic [8:0] e;
    e = 9'd1;
    for (int i = 0; i < 256; i++) begin
      if (i[7:0] == a) return e[7:0];
      e = 9'((18'(e) * 18'd45) % 18'd257);
    end
    return 8'd0;
  endfunction

  // Walk the same power sequence and return the exponent that hits a
  function automatic byte_t log45(input byte_t a);
    logic [8:0] e;
    e = 9'd1;
    for (int i = 0; i < 256; i++) begin
      if (e[7:0] == a) return i[7:0];
      e = 9'((18'(e) * 18'd45) % 18'd257);
    end
    return 8'd0;
  endfunction

  // Split 128 bits into bytes with byte 0 at the top
  function automatic block_t split(input logic [63:0] hi, input logic [63:0] lo);
    block_t b;
    for (int i = 0; i < 8; i++) begin
      b[i]     = hi[63-8*i -: 8];
      b[i + 8] = lo[63-8*i -: 8];
    end
    return b;
  endfunction

  function automatic block_t mix_add(input block_t x, input block_t k);
    block_t r;
    for (int i = 0; i < 16; i++) begin
      if (i % 4 == 0 || i % 4 == 3) r[i] = x[i] ^ k[i];
      else r[i] = x[i] + k[i];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/bluetooth_key_functions_unit.sv =====
// Channel | Ports                         | Handshake
// input   | start, busy, in_item          | accepted when start && !busy
// result  | done, out_item                | one-cycle strobe on done
// One item takes one pass (E21, E22) or two passes (E1, E3) of SAFER+.
// A pass is a load step, sixteen half-rounds and a final-key step; the key
// schedule steps once per half. Reset clears the sequencer only; results
// cannot be stalled.
module bluetooth_key_functions_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  bkf_pkg::bkf_in_t  in_item,
  output logic              busy,
  output logic              done,
  output bkf_pkg::bkf_out_t out_item
);
  import bkf_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_LOAD, S_RUN, S_FIN} st_t;
  localparam byte_t OFS [8] = '{8'd233, 8'd229, 8'd223, 8'd193,
                                8'd179, 8'd167, 8'd149, 8'd131};

  st_t      st;
  bkf_in_t  item;
  logic     pass2, half;
  logic [2:0] rnd;
  bkf_ctl_t ctl;
  block_t   key_sel, init_sel, subkey, state, rnd_b, rep, key_b;

  // Build the key and starting block for this pass
  always_comb begin
    block_t ok;
    rnd_b = split(item.rand_high, item.rand_low);
    key_b = split(item.key_high, item.key_low);
    for (int i = 0; i < 16; i++) begin
      if (item.action == ACT_E3) begin
        if (i % 12 < 4) rep[i] = item.aco_high[31-8*(i%12) -: 8];
        else rep[i] = item.aco_low[63-8*(i%12-4) -: 8];
      end else rep[i] = item.device_address[47-8*(i%6) -: 8];
    end
    for (int i = 0; i < 16; i++) begin
      if ((i < 8) ? (i % 2 == 0) : (i % 2 == 1)) ok[i] = key_b[i] + OFS[i%8];
      else ok[i] = key_b[i] ^ OFS[i%8];
    end
    key_sel  = key_b;
    init_sel = rnd_b;
    case (item.action)
      ACT_E21: begin
        key_sel[15] = key_b[15] ^ 8'd6;
        init_sel    = rep;
      end
      ACT_E22: init_sel[15] = rnd_b[15] ^ {3'd0, item.pin_length};
      default: begin
        if (pass2) begin
          key_sel = ok;
          for (int i = 0; i < 16; i++) init_sel[i] = (state[i] ^ rnd_b[i]) + rep[i];
        end
      end
    endcase
    ctl.load   = (st == S_LOAD);
    ctl.round  = (st == S_RUN);
    ctl.finish = (st == S_FIN);
    ctl.rnd    = rnd;
    ctl.fold   = (st == S_RUN) && !half && rnd == 3'd2 &&
                 (pass2 || item.action[1]);
  end

  bkf_keysched u_ks (
    .clk(clk), .load(ctl.load), .step(ctl.round), .key(key_sel), .subkey(subkey)
  );

  bkf_round u_rnd (
    .clk(clk), .ctl(ctl), .half(half), .init(init_sel), .subkey(subkey), .state(state)
  );

  assign out_item.result_high = {state[0], state[1], state[2], state[3],
                                 state[4], state[5], state[6], state[7]};
  assign out_item.result_low  = {state[8], state[9], state[10], state[11],
                                 state[12], state[13], state[14], state[15]};

  // Sequence load, sixteen half-rounds, final key, then second pass or done
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE; busy <= 1'b0; done <= 1'b0;
      pass2 <= 1'b0; half <= 1'b0; rnd <= 3'd0;
    end else begin
      done <= 1'b0;
      case (st)
        S_IDLE: if (start) begin
          item <= in_item; busy <= 1'b1; pass2 <= 1'b0; st <= S_LOAD;
        end
        S_LOAD: begin
          half <= 1'b0; rnd <= 3'd0; st <= S_RUN;
        end
        S_RUN: begin
          half <= !half;
          if (half) begin
            rnd <= rnd + 3'd1;
            if (rnd == 3'd7) st <= S_FIN;
          end
        end
        S_FIN: begin
          if (!pass2 && !item.action[1]) begin
            pass2 <= 1'b1; st <= S_LOAD;
          end else begin
            done <= 1'b1; busy <= 1'b0; st <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== hw/rtl/bkf_keysched.sv =====
module bkf_keysched (
  input  logic            clk,
  input  logic            load,
  input  logic            step,
  input  bkf_pkg::block_t key,
  output bkf_pkg::block_t subkey
);
  import bkf_pkg::*;

  byte_t [16:0] kreg;
  logic  [4:0]  p;
  block_t       sub_next;
  byte_t        par;

  // Derive next subkey: rotate register, select bytes, add bias
  always_comb begin
    byte_t [16:0] rot;
    logic  [4:0]  pn;
    logic  [7:0]  bi;
    logic  [5:0]  sel;
    pn = p + 5'd1;
    for (int j = 0; j < 17; j++) rot[j] = {kreg[j][4:0], kreg[j][7:5]};
    for (int j = 0; j < 16; j++) begin
      sel = 6'(pn) + 6'(j);
      if (sel >= 6'd17) sel = sel - 6'd17;
      bi = 8'(17 * pn + 18 + j);
      sub_next[j] = rot[sel[4:0]] + exp45(exp45(bi));
    end
    par = 8'd0;
    for (int j = 0; j < 16; j++) par = par ^ key[j];
  end

  // Hold key register, advance one subkey per step
  always_ff @(posedge clk) begin
    if (load) begin
      for (int j = 0; j < 16; j++) kreg[j] <= key[j];
      kreg[16] <= par;
      subkey   <= key;
      p        <= 5'd0;
    end else if (step) begin
      for (int j = 0; j < 17; j++) kreg[j] <= {kreg[j][4:0], kreg[j][7:5]};
      subkey <= sub_next;
      p      <= p + 5'd1;
    end
  end
endmodule

// ===== hw/rtl/bkf_round.sv =====
module bkf_round (
  input  logic            clk,
  input  bkf_pkg::bkf_ctl_t ctl,
  input  logic            half,
  input  bkf_pkg::block_t init,
  input  bkf_pkg::block_t subkey,
  output bkf_pkg::block_t state
);
  import bkf_pkg::*;

  localparam int PA [4][8] = '{'{0,2,4,6,8,10,12,14}, '{0,2,4,6,8,10,12,14},
                               '{0,2,4,6,8,10,12,14}, '{0,2,4,6,8,10,12,14}};
  localparam int PB [4][8] = '{'{1,3,5,7,9,11,13,15}, '{7,1,3,5,11,9,15,13},
                               '{3,15,7,1,5,13,11,9}, '{13,5,9,11,15,1,3,7}};
  localparam int SH [16] = '{14,7,8,15,0,13,6,11,4,9,2,5,10,1,12,3};

  block_t first, x_mid, x_out;

  // Both halves of a round: nonlinear layer with ka, then kb and PHT mixing
  always_comb begin
    block_t t, y;
    y = ctl.fold ? mix_add(state, first) : state;
    for (int i = 0; i < 16; i++) begin
      if (i % 4 == 0 || i % 4 == 3) x_mid[i] = exp45(y[i] ^ subkey[i]);
      else x_mid[i] = log45(y[i] + subkey[i]);
    end
    t = state;
    for (int i = 0; i < 16; i++) begin
      if (i % 4 == 0 || i % 4 == 3) t[i] = state[i] + subkey[i];
      else t[i] = state[i] ^ subkey[i];
    end
    for (int l = 0; l < 4; l++) begin
      for (int i = 0; i < 8; i++) begin
        t[PB[l][i]] = t[PB[l][i]] + t[PA[l][i]];
        t[PA[l][i]] = t[PA[l][i]] + t[PB[l][i]];
      end
      if (l == 3) begin
        y = t;
        for (int i = 0; i < 16; i++) t[i] = y[SH[i]];
      end
    end
    x_out = t;
  end

  // Hold block; first half uses ka, second half uses kb
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      state <= init;
      first <= init;
    end else if (ctl.round) begin
      state <= half ? x_out : x_mid;
    end else if (ctl.finish) begin
      state <= mix_add(state, subkey);
    end
  end
endmodule

// ===== tb/sv/bluetooth_key_functions_checker.sv =====
`timescale 1ns / 100ps

module bluetooth_key_functions_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  bkf_pkg::bkf_in_t  in_item,
  input  logic              done,
  input  bkf_pkg::bkf_out_t out_item,
  output int                fail_count,
  output int                pending_count,
  output int                result_count
);
  import bkf_pkg::*;

  typedef logic [7:0] blk_t [16];

  byte_t exp_lut [256];
  byte_t log_lut [256];
  bkf_out_t expected_results [$];

  // build the power and log tables of 45 mod 257
  initial begin
    int e;
    e = 1;
    for (int i = 0; i < 256; i++) begin
      exp_lut[i] = e[7:0];
      log_lut[e[7:0]] = i[7:0];
      e = (e * 45) % 257;
    end
  end

  function automatic void mixed_add(ref blk_t x, input blk_t k);
    for (int i = 0; i < 16; i++) begin
      if (i % 4 == 0 || i % 4 == 3) x[i] = x[i] ^ k[i];
      else x[i] = x[i] + k[i];
    end
  endfunction

  function automatic void safer_round(ref blk_t x, input blk_t ka, input blk_t kb);
    int pa [4][8];
    int pb [4][8];
    int shuf [16];
    blk_t t;
    pa = '{'{0,2,4,6,8,10,12,14}, '{0,2,4,6,8,10,12,14},
           '{0,2,4,6,8,10,12,14}, '{0,2,4,6,8,10,12,14}};
    pb = '{'{1,3,5,7,9,11,13,15}, '{7,1,3,5,11,9,15,13},
           '{3,15,7,1,5,13,11,9}, '{13,5,9,11,15,1,3,7}};
    shuf = '{14,7,8,15,0,13,6,11,4,9,2,5,10,1,12,3};
    for (int i = 0; i < 16; i++) begin
      if (i % 4 == 0 || i % 4 == 3) x[i] = exp_lut[x[i] ^ ka[i]] + kb[i];
      else x[i] = log_lut[8'(x[i] + ka[i])] ^ kb[i];
    end
    for (int l = 0; l < 4; l++) begin
      for (int i = 0; i < 8; i++) begin
        x[pb[l][i]] = x[pb[l][i]] + x[pa[l][i]];
        x[pa[l][i]] = x[pa[l][i]] + x[pb[l][i]];
      end
    end
    t = x;
    for (int i = 0; i < 16; i++) x[i] = t[shuf[i]];
  endfunction

  function automatic void safer_pass(ref blk_t x, input blk_t key, input bit fold);
    blk_t sub [17];
    blk_t entry;
    logic [7:0] sreg [17];
    sreg[16] = 0;
    for (int j = 0; j < 16; j++) begin
      sreg[j] = key[j];
      sreg[16] ^= key[j];
      sub[0][j] = key[j];
    end
    for (int p = 1; p <= 16; p++) begin
      for (int j = 0; j < 17; j++) sreg[j] = {sreg[j][4:0], sreg[j][7:5]};
      for (int j = 0; j < 16; j++)
        sub[p][j] = sreg[(p + j) % 17] + exp_lut[exp_lut[(17 * p + 18 + j) & 255]];
    end
    entry = x;
    for (int r = 0; r < 8; r++) begin
      if (fold && r == 2) mixed_add(x, entry);
      safer_round(x, sub[2 * r], sub[2 * r + 1]);
    end
    mixed_add(x, sub[16]);
  endfunction

  function automatic bkf_out_t key_function(input bkf_in_t it);
    blk_t key, rnd, rep, x, okey;
    logic [7:0] ofs [8];
    logic [95:0] aco;
    bkf_out_t r;
    ofs = '{233, 229, 223, 193, 179, 167, 149, 131};
    aco = {it.aco_high, it.aco_low};
    for (int i = 0; i < 8; i++) begin
      key[i] = it.key_high[63 - 8 * i -: 8];
      key[i + 8] = it.key_low[63 - 8 * i -: 8];
      rnd[i] = it.rand_high[63 - 8 * i -: 8];
      rnd[i + 8] = it.rand_low[63 - 8 * i -: 8];
    end
    for (int i = 0; i < 16; i++) begin
      if (it.action == ACT_E3) rep[i] = aco[95 - 8 * (i % 12) -: 8];
      else rep[i] = it.device_address[47 - 8 * (i % 6) -: 8];
    end
    case (it.action)
      ACT_E1, ACT_E3: begin
        x = rnd;
        safer_pass(x, key, 0);
        for (int i = 0; i < 16; i++) x[i] = (x[i] ^ rnd[i]) + rep[i];
        for (int i = 0; i < 16; i++) begin
          if ((i < 8) == (i % 2 == 0)) okey[i] = key[i] + ofs[i % 8];
          else okey[i] = key[i] ^ ofs[i % 8];
        end
        safer_pass(x, okey, 1);
      end
      ACT_E21: begin
        key[15] ^= 8'd6;
        x = rep;
        safer_pass(x, key, 1);
      end
      default: begin
        x = rnd;
        x[15] ^= {3'b0, it.pin_length};
        safer_pass(x, key, 1);
      end
    endcase
    for (int i = 0; i < 8; i++) begin
      r.result_high[63 - 8 * i -: 8] = x[i];
      r.result_low[63 - 8 * i -: 8] = x[i + 8];
    end
    return r;
  endfunction

  assign pending_count = expected_results.size();

  // predict on each accepted item, compare on each result strobe
  always @(posedge clk) begin
    bkf_out_t want;
    int errs;
    errs = 0;
    if (rst) begin
      fail_count <= 0;
      result_count <= 0;
    end else begin
      if (start && !busy) expected_results.push_back(key_function(in_item));
      if (done) begin
        result_count <= result_count + 1;
        if (expected_results.size() == 0) begin
          $error("result with no item outstanding");
          errs++;
        end else begin
          want = expected_results.pop_front();
          if (want.result_high !== out_item.result_high) begin
            $error("result_high expected %h actual %h", want.result_high,
                   out_item.result_high);
            errs++;
          end
          if (want.result_low !== out_item.result_low) begin
            $error("result_low expected %h actual %h", want.result_low,
                   out_item.result_low);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count <= fail_count + errs;
    end
  end
endmodule

// ===== tb/sv/tb_bluetooth_key_functions_unit.sv =====
`timescale 1ns / 100ps

module tb_bluetooth_key_functions_unit;
  import bkf_pkg::*;

  localparam int NUM_RANDOM = 1850;
  localparam int CYCLE_LIMIT = 400000;

  logic clk;
  logic rst;
  logic start;
  bkf_in_t in_item;
  logic busy;
  logic done;
  bkf_out_t out_item;
  int fail_count;
  int pending_count;
  int result_count;
  int cycle_count;
  int action_count [4];

  bluetooth_key_functions_unit i_dut (
    .clk(clk), .rst(rst), .start(start), .in_item(in_item),
    .busy(busy), .done(done), .out_item(out_item)
  );

  bluetooth_key_functions_checker i_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .in_item(in_item),
    .done(done), .out_item(out_item), .fail_count(fail_count),
    .pending_count(pending_count), .result_count(result_count)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_bluetooth_key_functions_unit failed");
      $finish;
    end
  end

  function automatic logic [63:0] rand64(input int sel);
    case (sel)
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // present one item and hold it until accepted; start drops only in idle cycles
  task automatic send_item(input bkf_in_t it, input bit gaps);
    if (gaps) begin
      while ($urandom_range(99) < 37) begin
        start <= 0;
        @(negedge clk);
      end
    end
    start <= 1;
    in_item <= it;
    action_count[it.action]++;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic bkf_in_t random_item(input int ext);
    bkf_in_t it;
    it.action = 2'($urandom_range(3));
    it.key_high = rand64(ext);
    it.key_low = rand64(ext);
    it.rand_high = rand64(ext);
    it.rand_low = rand64(ext);
    it.device_address = 48'(rand64(ext));
    it.aco_high = 32'(rand64(ext));
    it.aco_low = rand64(ext);
    it.pin_length = 5'($urandom_range(1, 16));
    if ($urandom_range(19) == 0) it.pin_length = 5'($urandom);
    return it;
  endfunction

  initial begin
    bkf_in_t it;
    logic [1:0] acts [4];
    acts = '{ACT_E1, ACT_E3, ACT_E21, ACT_E22};
    cycle_count = 0;
    rst = 1;
    start = 0;
    in_item = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: each function with all-zero, all-one and random fields
    for (int a = 0; a < 4; a++) begin
      for (int ext = 0; ext < 3; ext++) begin
        it = random_item(ext);
        it.action = acts[a];
        it.pin_length = (ext == 0) ? 5'd1 : (ext == 1) ? 5'd16 : 5'd31;
        send_item(it, 0);
      end
    end
    it = random_item(2);
    it.action = ACT_E22;
    it.pin_length = 5'd0;
    send_item(it, 0);

    // random: gaps except for a long burst in the middle
    for (int n = 0; n < NUM_RANDOM; n++) begin
      it = random_item($urandom_range(49) == 0 ? $urandom_range(1) : 2);
      send_item(it, !(n >= 600 && n < 900));
    end
    start <= 0;

    while (pending_count != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("covered %0d results: E1 %0d, E3 %0d, E21 %0d, E22 %0d", result_count,
             action_count[0], action_count[1], action_count[2], action_count[3]);
    if (fail_count == 0 && pending_count == 0) begin
      $display("tb_bluetooth_key_functions_unit passed");
    end else begin
      $display("tb_bluetooth_key_functions_unit failed");
    end
    $finish;
  end
endmodule

// ===== bluetooth_key_functions_unit.f =====
hw/rtl/bkf_pkg.sv
hw/rtl/bkf_keysched.sv
hw/rtl/bkf_round.sv
hw/rtl/bluetooth_key_functions_unit.sv
tb/sv/bluetooth_key_functions_checker.sv
tb/sv/tb_bluetooth_key_functions_unit.sv
